// File: rtl/qts_pkg.sv
package qts_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int AW          = $clog2(STACK_DEPTH);
  localparam int CW          = $clog2(STACK_DEPTH + 1);
  localparam int CAP_W       = 8;
  localparam int CMP_W       = (CW > CAP_W) ? CW : CAP_W;
  localparam int CAP_RESET   = 128;
  localparam int BYTE_W      = 8;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// File: rtl/qts_if.sv
interface qts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] push_byte;

  modport source (output valid, output cmd, output push_byte, input ready);
  modport sink   (input valid, input cmd, input push_byte, output ready);
endinterface

interface qts_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] popped_byte;
  logic       is_empty;

  modport source (output valid, output status, output popped_byte, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input popped_byte, input is_empty,
                  output ready);
endinterface

interface qts_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] queue_capacity;

  modport source (output valid, output queue_capacity, input ready);
  modport sink   (input valid, input queue_capacity, output ready);
endinterface

// File: rtl/qts_ram.sv
module qts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/two_stack_fifo_queue_top.sv
// Channel  Dir  Payload                          Request taken when
// req      in   cmd, push_byte                   req.valid && req.ready
// rsp      out  status, popped_byte, is_empty    rsp.valid && rsp.ready
// cfg      in   queue_capacity                   cfg.valid (ready held high)
//
// Enqueue, empty query and failed dequeue: answer registered in the cycle after the request.
// Dequeue with bytes on the output stack: S_POP, then S_DONE, which registers the memory read data.
// Dequeue that refills the output stack: S_XFER moves the whole in stack, one byte per cycle, then S_POP, S_DONE.
// Reset clears counts and sets capacity to CAP_RESET at once; no memory clearing pass.
// A new request is taken while a response waits, once the output register will be free.
module two_stack_fifo_queue_top (
  input  logic       clk,
  input  logic       rst,
  qts_req_if.sink    req,
  qts_rsp_if.source  rsp,
  qts_cfg_if.sink    cfg
);
  import qts_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_XFER, S_POP, S_DONE} state_t;

  state_t              state;
  logic [CW-1:0]       in_count;
  logic [CW-1:0]       out_count;
  logic [CW-1:0]       item_count;
  logic [CAP_W-1:0]    capacity;
  logic                xfer_pend;
  logic                rsp_valid;
  logic [1:0]          rsp_status;
  logic [BYTE_W-1:0]   rsp_byte;
  logic                rsp_empty;

  logic                req_fire;
  logic                rsp_load;
  logic                full;
  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    eff_cap;
  logic [CW-1:0]       in_dec;
  logic [CW-1:0]       out_dec;
  logic                in_we;
  logic                out_we;
  logic [BYTE_W-1:0]   in_rdata;
  logic [BYTE_W-1:0]   out_rdata;

  assign req.ready       = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign req_fire        = req.valid && req.ready;
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.popped_byte = rsp_byte;
  assign rsp.is_empty    = rsp_empty;

  assign rsp_load = (state == S_DONE) ||
                    (req_fire && ((req.cmd != CMD_DEQ) || (item_count == '0)));

  assign cap_ext = CMP_W'(capacity);
  assign eff_cap = (cap_ext < CMP_W'(STACK_DEPTH)) ? cap_ext : CMP_W'(STACK_DEPTH);
  assign full    = (CMP_W'(item_count) >= eff_cap) || (in_count >= CW'(STACK_DEPTH));
  assign in_dec  = in_count - CW'(1);
  assign out_dec = out_count - CW'(1);
  assign in_we   = req_fire && (req.cmd == CMD_ENQ) && !full;
  assign out_we  = (state == S_XFER) && xfer_pend;

  qts_ram #(.WIDTH(BYTE_W), .DEPTH(STACK_DEPTH)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_count[AW-1:0]),
    .wdata (req.push_byte),
    .raddr (in_dec[AW-1:0]),
    .rdata (in_rdata)
  );

  qts_ram #(.WIDTH(BYTE_W), .DEPTH(STACK_DEPTH)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_count[AW-1:0]),
    .wdata (in_rdata),
    .raddr (out_dec[AW-1:0]),
    .rdata (out_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_count   <= '0;
      out_count  <= '0;
      item_count <= '0;
      capacity   <= CAP_W'(CAP_RESET);
      xfer_pend  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.queue_capacity;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            rsp_byte <= '0;
            case (req.cmd)
              CMD_ENQ: begin
                if (full) begin
                  rsp_status <= ST_FULL;
                  rsp_empty  <= (item_count == '0);
                end else begin
                  rsp_status <= ST_OK;
                  rsp_empty  <= 1'b0;
                  in_count   <= in_count + CW'(1);
                  item_count <= item_count + CW'(1);
                end
              end
              CMD_DEQ: begin
                if (item_count == '0) begin
                  rsp_status <= ST_EMPTY;
                  rsp_empty  <= 1'b1;
                end else if (out_count == '0) begin
                  xfer_pend <= 1'b0;
                  state     <= S_XFER;
                end else begin
                  state <= S_POP;
                end
              end
              default: begin
                rsp_status <= ST_OK;
                rsp_empty  <= (item_count == '0);
              end
            endcase
          end
        end
        S_XFER: begin
          // each out stack write lands in the cycle after its in stack read, overlapping the next read
          if (in_count != '0) begin
            in_count  <= in_dec;
            xfer_pend <= 1'b1;
          end else begin
            xfer_pend <= 1'b0;
          end
          if (xfer_pend) begin
            out_count <= out_count + CW'(1);
          end
          if ((in_count == '0) && !xfer_pend) begin
            state <= S_POP;
          end
        end
        S_POP: begin
          out_count  <= out_dec;
          item_count <= item_count - CW'(1);
          state      <= S_DONE;
        end
        S_DONE: begin
          rsp_status <= ST_OK;
          rsp_byte   <= out_rdata;
          rsp_empty  <= (item_count == '0);
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/two_stack_fifo_queue_top_test.sv
`timescale 1ns / 100ps

module two_stack_fifo_queue_top_test;
  import qts_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, behaves as a query
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    status_t    status;
    logic [7:0] popped_byte;
    logic       is_empty;
  } queue_reply_t;

  class queue_scoreboard;
    logic [7:0]   in_lifo[STACK_DEPTH];
    logic [7:0]   out_lifo[STACK_DEPTH];
    int unsigned  in_fill;
    int unsigned  out_fill;
    int unsigned  held;
    int unsigned  capacity;
    queue_reply_t replies_due[$];
    int           errors;

    function new();
      in_fill = 0;
      out_fill = 0;
      held = 0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [7:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] data);
      queue_reply_t r;
      int unsigned  limit;
      limit = (capacity < STACK_DEPTH) ? capacity : STACK_DEPTH;
      r.status = ST_OK;
      r.popped_byte = 8'd0;
      if (op == CMD_ENQ) begin
        if (held >= limit || in_fill >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          in_lifo[in_fill] = data;
          in_fill++;
          held++;
        end
      end else if (op == CMD_DEQ) begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (out_fill == 0) begin
            while (in_fill > 0 && out_fill < STACK_DEPTH) begin
              in_fill--;
              out_lifo[out_fill] = in_lifo[in_fill];
              out_fill++;
            end
          end
          if (out_fill > 0) begin
            out_fill--;
            r.popped_byte = out_lifo[out_fill];
            held--;
          end else begin
            r.status = ST_EMPTY;
          end
        end
      end
      r.is_empty = (held == 0);
      replies_due.push_back(r);
    endfunction

    function void check_response(logic [1:0] status, logic [7:0] popped, logic empty);
      queue_reply_t r;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: response with no request outstanding: status %0d byte %0h empty %0d",
                   $time, status, popped, empty);
        return;
      end
      r = replies_due.pop_front();
      if (status !== r.status || popped !== r.popped_byte || empty !== r.is_empty) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch: status %0d/%0d byte %0h/%0h empty %0d/%0d (exp/got)",
                   $time, r.status, status, r.popped_byte, popped, r.is_empty, empty);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   idle_cycles;
  bit   req_idle;

  queue_scoreboard sb;

  qts_req_if req_ch ();
  qts_rsp_if rsp_ch ();
  qts_cfg_if cfg_ch ();

  two_stack_fifo_queue_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_request(input logic [1:0] op, input logic [7:0] data);
    int g;
    g = req_idle ? idle_gap() : 0;
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= op;
    req_ch.push_byte <= data;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, data);
    @(negedge clk);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [7:0] cap);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.queue_capacity <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_capacity(cap);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_requests(input int count, input int enq_pct, input bit idle);
    int r;
    logic [1:0] op;
    req_idle = idle;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) op = CMD_ENQ;
      else if (r < 95) op = CMD_DEQ;
      else if (r < 98) op = CMD_QUERY;
      else op = CMD_SPARE;
      send_request(op, 8'($urandom_range(0, 255)));
    end
  endtask

  // response side back-pressure
  initial begin
    int n;
    int g;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      n = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
      rsp_ch.ready <= 1'b1;
      repeat (n) @(negedge clk);
      g = idle_gap();
      if (g > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.status, rsp_ch.popped_byte, rsp_ch.is_empty);
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    req_idle = 1'b1;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_QUERY;
    req_ch.push_byte = 8'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.queue_capacity = 8'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty queue, spare code, refill of the output stack twice
    send_request(CMD_QUERY, 8'h00);
    send_request(CMD_DEQ, 8'hFF);
    send_request(CMD_SPARE, 8'hFF);
    send_request(CMD_ENQ, 8'h00);
    send_request(CMD_ENQ, 8'hFF);
    send_request(CMD_ENQ, 8'h80);
    send_request(CMD_ENQ, 8'h01);
    send_request(CMD_DEQ, 8'h00);
    send_request(CMD_ENQ, 8'h7F);
    repeat (4) send_request(CMD_DEQ, 8'h00);
    send_request(CMD_DEQ, 8'h00);

    // zero capacity
    write_capacity(8'd0);
    send_request(CMD_ENQ, 8'hAA);
    send_request(CMD_QUERY, 8'h00);

    // full at a small capacity
    write_capacity(8'd2);
    send_request(CMD_ENQ, 8'h55);
    send_request(CMD_ENQ, 8'hA5);
    send_request(CMD_ENQ, 8'h5A);
    repeat (3) send_request(CMD_DEQ, 8'h00);

    // capacity lowered below the fill
    write_capacity(8'd128);
    repeat (3) send_request(CMD_ENQ, 8'($urandom_range(0, 255)));
    write_capacity(8'd1);
    send_request(CMD_ENQ, 8'h11);
    send_request(CMD_DEQ, 8'h00);
    send_request(CMD_ENQ, 8'h22);
    send_request(CMD_DEQ, 8'h00);
    send_request(CMD_DEQ, 8'h00);
    send_request(CMD_ENQ, 8'h33);

    write_capacity(8'd255);
    random_requests(250, 80, 1'b0);
    write_capacity(8'd128);
    random_requests(200, 50, 1'b1);
    write_capacity(8'd1);
    random_requests(60, 50, 1'b1);
    write_capacity(8'd129);
    random_requests(150, 60, 1'b1);
    repeat (3) begin
      write_capacity(8'($urandom_range(0, 255)));
      random_requests(80, 55, 1'($urandom_range(0, 1)));
    end

    settle();
    repeat (150) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
rtl/qts_pkg.sv
rtl/qts_if.sv
rtl/qts_ram.sv
rtl/two_stack_fifo_queue_top.sv
tb/sv/two_stack_fifo_queue_top_test.sv
